// ----- rtl/core/bfha_pkg.sv -----
package bfha_pkg;

    localparam int TableDepth  = 16;
    localparam int HeaderBytes = 12;
    localparam int FooterBytes = 8;
    localparam int IdxW        = $clog2(TableDepth);
    localparam int CntW        = $clog2(TableDepth + 1);

    localparam logic [31:0] Overhead = 32'(HeaderBytes + FooterBytes);
    localparam logic [31:0] HdrW     = 32'(HeaderBytes);

    // configuration register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_DONE
    } t_state;

    // Command from the sequencer to every cell for one cycle.
    typedef struct packed {
        logic        rotate;   // every cell takes its right neighbor's entry
        logic        shift;    // cells at and above pos take right neighbor
        logic [IdxW-1:0] pos;
        logic        load;     // cell at ldpos takes ld data
        logic [IdxW-1:0] ldpos;
        logic [31:0] ld_addr;
        logic [31:0] ld_size;
    } t_cell_cmd;

endpackage

// ----- rtl/core/bfha_cell.sv -----
module bfha_cell (
    input  logic                 i_clk,
    input  bfha_pkg::t_cell_cmd  i_cmd,
    input  logic [bfha_pkg::IdxW-1:0] i_idx,
    input  logic [31:0]          i_nb_addr,
    input  logic [31:0]          i_nb_size,
    output logic [31:0]          o_addr,
    output logic [31:0]          o_size
);
    import bfha_pkg::*;

    logic [31:0] r_addr, r_size;
    logic [31:0] n_addr, n_size;

    always_comb begin
        n_addr = r_addr;
        n_size = r_size;
        if (i_cmd.rotate || (i_cmd.shift && i_idx >= i_cmd.pos)) begin
            n_addr = i_nb_addr;
            n_size = i_nb_size;
        end
        if (i_cmd.load && i_idx == i_cmd.ldpos) begin
            n_addr = i_cmd.ld_addr;
            n_size = i_cmd.ld_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_size <= n_size;
    end

    assign o_addr = r_addr;
    assign o_size = r_size;
endmodule

// ----- rtl/core/best_fit_hole_allocator_top.sv -----
// Best-fit hole allocator. Holes sit in a ring of TableDepth cells; an
// allocate rotates the ring a full turn past cell 0, comparing one entry a
// cycle, then decides the split in S_PICK and, in S_SHIFT, removes the
// chosen hole and appends the split tail. Init loads one hole spanning
// the region in S_SCAN and reports from S_DONE; free and unused ops
// report from S_SCAN. A new start is taken only while idle. busy rises
// after the accepting edge and falls with the strobe; o_valid pulses for
// one cycle and the result must be taken then, since the receiver cannot
// stall. Write the configuration registers only while busy is low and no
// result is pending.
module best_fit_hole_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_block_addr,
    output logic        o_valid,
    output logic [31:0] o_data_addr,
    output logic [1:0]  o_status,
    output logic [31:0] o_occupied_bytes,
    output logic [4:0]  o_hole_count
);
    import bfha_pkg::*;

    t_state r_state, n_state;
    logic [31:0] r_hstart, r_hend;
    logic [1:0]  r_op;
    logic [31:0] r_size, r_baddr;
    logic [CntW-1:0] r_used, n_used;
    logic [31:0] r_occ, n_occ;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic        r_found, n_found, r_exact, n_exact;
    logic [IdxW-1:0] r_best, n_best;
    logic [31:0] r_baddr_h, n_baddr_h, r_bsize, n_bsize;
    logic        r_ok, n_ok;
    logic        r_valid, n_valid;
    logic [31:0] r_data, n_data;
    logic [1:0]  r_stat, n_stat;
    t_cell_cmd   cmd;

    logic [31:0] c_addr [TableDepth];
    logic [31:0] c_size [TableDepth];

    for (genvar g = 0; g < TableDepth; g++) begin : g_cell
        localparam int Nb = (g + 1) % TableDepth;
        bfha_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cmd),
            .i_idx     (IdxW'(g)),
            .i_nb_addr (c_addr[Nb]),
            .i_nb_size (c_size[Nb]),
            .o_addr    (c_addr[g]),
            .o_size    (c_size[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hstart <= '0;
            r_hend   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_END) r_hend <= i_cfg_data;
            else r_hstart <= i_cfg_data;
        end
    end

    logic [31:0] cap, avail, surplus, dec_lo;
    logic        dec_hi;
    logic        fit_ok;
    logic [CntW-1:0] used_m1;

    always_comb begin
        cap     = r_hend - r_hstart;
        avail   = (r_occ >= cap) ? 32'd0 : cap - r_occ;
        surplus = r_bsize - r_size;
        {dec_hi, dec_lo} = {1'b0, r_size} + {1'b0, Overhead};
        used_m1 = r_used - 1'b1;
        fit_ok  = r_baddr != 0 && r_baddr < r_hend && r_baddr > r_hstart;
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_occ     = r_occ;
        n_cnt     = r_cnt;
        n_found   = r_found;
        n_exact   = r_exact;
        n_best    = r_best;
        n_baddr_h = r_baddr_h;
        n_bsize   = r_bsize;
        n_ok      = r_ok;
        n_valid   = 1'b0;
        n_data    = '0;
        n_stat    = ST_OK;
        cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SCAN;
                n_cnt   = '0;
                n_found = 1'b0;
                n_exact = 1'b0;
                n_best  = '0;
            end
            S_SCAN: begin
                case (t_op'(r_op))
                    OP_INIT: begin
                        n_occ  = '0;
                        n_used = CntW'(1);
                        cmd.load    = 1'b1;
                        cmd.ldpos   = '0;
                        cmd.ld_addr = r_hstart;
                        cmd.ld_size = r_hend - r_hstart - Overhead;
                        n_state = S_DONE;
                    end
                    OP_FREE: begin
                        if (fit_ok) begin
                            if (r_used < CntW'(TableDepth)) begin
                                cmd.load    = 1'b1;
                                cmd.ldpos   = IdxW'(r_used);
                                cmd.ld_addr = r_baddr - HdrW;
                                cmd.ld_size = r_size;
                                n_used = r_used + 1'b1;
                            end
                            n_occ = (dec_hi || dec_lo >= r_occ) ? 32'd0 : r_occ - dec_lo;
                            n_stat = ST_OK;
                        end else begin
                            n_stat = ST_RANGE;
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_ALLOC: begin
                        // Rotate a full turn; entry at cell 0 is table slot r_cnt.
                        cmd.rotate = 1'b1;
                        if (avail >= r_size && r_cnt < r_used && !r_exact
                                && c_size[0] >= r_size) begin
                            if (c_size[0] == r_size || !r_found || c_size[0] < r_bsize) begin
                                n_best    = IdxW'(r_cnt);
                                n_bsize   = c_size[0];
                                n_baddr_h = c_addr[0];
                                n_found   = 1'b1;
                                n_exact   = c_size[0] == r_size;
                            end
                        end
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == CntW'(TableDepth - 1)) n_state = S_PICK;
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_PICK: begin
                n_ok = r_found && surplus > Overhead;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_found) begin
                    cmd.shift = 1'b1;
                    cmd.pos   = r_best;
                    n_used    = used_m1;
                    if (r_ok) begin
                        cmd.load    = 1'b1;
                        cmd.ldpos   = IdxW'(used_m1);
                        cmd.ld_addr = r_baddr_h + HdrW + r_size + 32'(FooterBytes);
                        cmd.ld_size = surplus - Overhead;
                        n_used      = r_used;
                        n_occ = r_occ + r_size + Overhead;
                    end else begin
                        n_occ = r_occ + r_bsize + Overhead;
                    end
                    n_data = r_baddr_h + HdrW;
                end else begin
                    n_stat = ST_NOFIT;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op    <= i_op;
            r_size  <= i_size_bytes;
            r_baddr <= i_block_addr;
        end
        r_cnt     <= n_cnt;
        r_found   <= n_found;
        r_exact   <= n_exact;
        r_best    <= n_best;
        r_baddr_h <= n_baddr_h;
        r_bsize   <= n_bsize;
        r_ok      <= n_ok;
        r_data    <= n_data;
        r_stat    <= n_stat;
    end

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_valid;
    assign o_data_addr      = r_data;
    assign o_status         = r_stat;
    assign o_occupied_bytes = r_occ;
    assign o_hole_count     = 5'(r_used);

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CntW'(TableDepth))
        else $error("hole count above table depth");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
    a_busy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy)
        else $error("result while still busy");
    a_nofit_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_stat != ST_OK) |-> r_data == '0)
        else $error("address on failed beat");
endmodule

// ----- bench/best_fit_hole_allocator_top_tb.sv -----
module best_fit_hole_allocator_top_tb;
    import bfha_pkg::*;

    typedef struct {
        t_op         op;
        logic [31:0] size;
        logic [31:0] addr;
        bit          known;
        logic [31:0] x_data;
        t_status     x_status;
        logic [31:0] x_occ;
        logic [4:0]  x_cnt;
    } t_row;

    typedef struct packed {
        logic [31:0] data;
        t_status     status;
        logic [31:0] occ;
        logic [4:0]  cnt;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic [1:0]  i_op = '0;
    logic [31:0] i_size_bytes = '0;
    logic [31:0] i_block_addr = '0;
    logic        o_valid;
    logic [31:0] o_data_addr;
    logic [1:0]  o_status;
    logic [31:0] o_occupied_bytes;
    logic [4:0]  o_hole_count;

    // predictor state
    logic [31:0] mdl_start, mdl_end, mdl_occ;
    logic [31:0] mdl_addr [TableDepth];
    logic [31:0] mdl_size [TableDepth];
    int          mdl_used;

    t_alloc_result pending_results[$];
    int errors = 0;
    int mismatches = 0;
    int send_idle = 0;
    logic [31:0] live_addr[$];
    logic [31:0] live_size[$];

    best_fit_hole_allocator_top i_dut (.*);

    always #6 i_clk = ~i_clk;

    initial begin
        #60000000;
        $display("best_fit_hole_allocator_top_tb NOT OK");
        $finish;
    end

    function automatic void push_hole(logic [31:0] a, logic [31:0] s);
        if (mdl_used < TableDepth) begin
            mdl_addr[mdl_used] = a;
            mdl_size[mdl_used] = s;
            mdl_used++;
        end
    endfunction

    function automatic t_alloc_result predict(t_op op, logic [31:0] size, logic [31:0] addr);
        t_alloc_result r;
        logic [31:0] cap, avail, min_size, base, blk, surplus;
        logic [32:0] dec;
        int best;
        bit found;
        r.data = '0;
        r.status = ST_OK;
        found = 0;
        best = 0;
        min_size = '0;
        case (op)
            OP_INIT: begin
                mdl_used = 0;
                mdl_occ = '0;
                push_hole(mdl_start, mdl_end - mdl_start - Overhead);
            end
            OP_ALLOC: begin
                cap = mdl_end - mdl_start;
                avail = (mdl_occ >= cap) ? 32'd0 : cap - mdl_occ;
                if (avail >= size) begin
                    for (int i = 0; i < mdl_used; i++) begin
                        if (!(found && min_size == size) && mdl_size[i] >= size) begin
                            if (mdl_size[i] == size || !found || mdl_size[i] < min_size) begin
                                best = i;
                                min_size = mdl_size[i];
                                found = 1;
                            end
                        end
                    end
                end
                if (found) begin
                    base = mdl_addr[best];
                    blk = min_size;
                    surplus = min_size - size;
                    for (int i = best + 1; i < mdl_used; i++) begin
                        mdl_addr[i-1] = mdl_addr[i];
                        mdl_size[i-1] = mdl_size[i];
                    end
                    mdl_used--;
                    if (surplus > Overhead && mdl_used < TableDepth) begin
                        push_hole(base + Overhead + size, surplus - Overhead);
                        blk = size;
                    end
                    r.data = base + HdrW;
                    mdl_occ = mdl_occ + blk + Overhead;
                end else begin
                    r.status = ST_NOFIT;
                end
            end
            OP_FREE: begin
                if (addr != 0 && addr < mdl_end && addr > mdl_start) begin
                    dec = {1'b0, size} + {1'b0, Overhead};
                    push_hole(addr - HdrW, size);
                    mdl_occ = (dec >= {1'b0, mdl_occ}) ? 32'd0 : mdl_occ - dec[31:0];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.occ = mdl_occ;
        r.cnt = 5'(mdl_used);
        return r;
    endfunction

    // results cannot be held off: check on every strobe
    always @(posedge i_clk) begin
        t_alloc_result x;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected beat addr=%h", o_data_addr);
            end else begin
                x = pending_results.pop_front();
                if (o_data_addr !== x.data || o_status !== x.status ||
                    o_occupied_bytes !== x.occ || o_hole_count !== x.cnt) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp %h/%0d/%h/%0d got %h/%0d/%h/%0d",
                                 x.data, x.status, x.occ, x.cnt, o_data_addr, o_status,
                                 o_occupied_bytes, o_hole_count);
                end
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_START) mdl_start = v;
        else mdl_end = v;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TableDepth + 8) @(negedge i_clk);
    endtask

    // one beat; start stays high only until the accepting edge
    task automatic issue(t_op op, logic [31:0] size, logic [31:0] addr, bit known,
                         t_alloc_result want);
        t_alloc_result r;
        int gap;
        gap = (send_idle > 0 && $urandom_range(99) < send_idle) ? $urandom_range(30) : 0;
        repeat (gap + 1) @(negedge i_clk);
        i_op <= op;
        i_size_bytes <= size;
        i_block_addr <= addr;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = predict(op, size, addr);
        if (known && r != want) begin
            errors++;
            if (mismatches++ < 10) $display("table row disagrees with predictor op=%0d", op);
        end
        pending_results.push_back(r);
        if (op == OP_ALLOC && r.status == ST_OK) begin
            live_addr.push_back(r.data);
            live_size.push_back(size);
        end
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic random_beat();
        int k, pick;
        logic [31:0] sz;
        k = $urandom_range(99);
        if (k < 3) begin
            issue(OP_INIT, $urandom, $urandom, 0, '0);
            live_addr.delete();
            live_size.delete();
        end else if (k < 50) begin
            case ($urandom_range(5))
                0: sz = $urandom;
                1: sz = $urandom_range(4000);
                default: sz = $urandom_range(200);
            endcase
            issue(OP_ALLOC, sz, $urandom, 0, '0);
        end else if (k < 88 && live_addr.size() != 0) begin
            pick = $urandom_range(live_addr.size() - 1);
            issue(OP_FREE, live_size[pick], live_addr[pick], 0, '0);
            live_addr.delete(pick);
            live_size.delete(pick);
        end else if (k < 96) begin
            issue(OP_FREE, $urandom, $urandom, 0, '0);
        end else begin
            issue(OP_NONE, $urandom, $urandom, 0, '0);
        end
    endtask

    t_row directed[] = '{
        '{OP_ALLOC, 32'd0, 32'd0, 1, 32'd0, ST_NOFIT, 32'd0, 5'd0},
        '{OP_FREE, 32'd0, 32'd0, 1, 32'd0, ST_RANGE, 32'd0, 5'd0},
        '{OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'd0, ST_OK, 32'd0, 5'd0},
        '{OP_INIT, 32'd0, 32'd0, 1, 32'd0, ST_OK, 32'd0, 5'd1},
        '{OP_ALLOC, 32'd100, 32'd0, 0, '0, ST_OK, '0, '0},
        '{OP_ALLOC, 32'd100, 32'd0, 0, '0, ST_OK, '0, '0},
        '{OP_ALLOC, 32'hFFFFFFFF, 32'd0, 0, '0, ST_OK, '0, '0},
        '{OP_FREE, 32'd100, 32'h0000100C, 0, '0, ST_OK, '0, '0},
        '{OP_ALLOC, 32'd100, 32'd0, 0, '0, ST_OK, '0, '0},
        '{OP_ALLOC, 32'd30, 32'd0, 0, '0, ST_OK, '0, '0},
        '{OP_FREE, 32'd30, 32'h00001000, 0, '0, ST_OK, '0, '0},
        '{OP_FREE, 32'd30, 32'h00002000, 0, '0, ST_OK, '0, '0},
        '{OP_FREE, 32'd30, 32'hFFFFFFFF, 0, '0, ST_OK, '0, '0},
        '{OP_FREE, 32'hFFFFFFFF, 32'h00001100, 0, '0, ST_OK, '0, '0},
        '{OP_ALLOC, 32'd1, 32'd0, 0, '0, ST_OK, '0, '0}
    };

    initial begin
        t_alloc_result want;
        mdl_start = '0;
        mdl_end = '0;
        mdl_occ = '0;
        mdl_used = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[i]) begin
            if (i == 4) begin
                drain();
                write_reg(CFG_START, 32'h00001000);
                write_reg(CFG_END, 32'h00002000);
                issue(OP_INIT, '0, '0, 0, '0);
            end
            want = '{directed[i].x_data, directed[i].x_status, directed[i].x_occ,
                     directed[i].x_cnt};
            issue(directed[i].op, directed[i].size, directed[i].addr, directed[i].known, want);
        end
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin write_reg(CFG_START, 32'h00010000); write_reg(CFG_END, 32'h00011000); end
                1: begin write_reg(CFG_START, 32'hFFFFFFFF); write_reg(CFG_END, 32'h00000FFF); end
                2: begin write_reg(CFG_START, 32'd0); write_reg(CFG_END, 32'hFFFFFFFF); end
                3: begin write_reg(CFG_START, 32'h8000_0000); write_reg(CFG_END, 32'h8000_0400); end
                default: begin write_reg(CFG_START, $urandom); write_reg(CFG_END, $urandom); end
            endcase
            send_idle = (ph == 1 || ph == 4) ? 85 : (ph == 3 ? 15 : 0);
            issue(OP_INIT, '0, '0, 0, '0);
            live_addr.delete();
            live_size.delete();
            for (int n = 0; n < 245; n++) begin
                if (n == 120) drain();
                random_beat();
            end
        end
        drain();
        if (errors == 0 && pending_results.size() == 0)
            $display("best_fit_hole_allocator_top_tb OK");
        else
            $display("best_fit_hole_allocator_top_tb NOT OK");
        $finish;
    end
endmodule
